FILE: src/ppp_pkg.sv
package ppp_pkg;

    localparam int WordW = 32;
    localparam int ProdW = 64;
    localparam int QuoW = 35;
    localparam int StatusW = 2;
    localparam int CfgIdxW = 2;

    localparam logic [StatusW-1:0] StOk = 2'd0;
    localparam logic [StatusW-1:0] StZero = 2'd1;
    localparam logic [StatusW-1:0] StSat = 2'd2;

    localparam logic [CfgIdxW-1:0] RegFocalX = 2'd0;
    localparam logic [CfgIdxW-1:0] RegFocalY = 2'd1;
    localparam logic [CfgIdxW-1:0] RegCenterX = 2'd2;
    localparam logic [CfgIdxW-1:0] RegCenterY = 2'd3;

    localparam logic [WordW-1:0] FocalReset = 32'h0001_0000;

    typedef struct packed {
        logic signed [WordW-1:0] point_x;
        logic signed [WordW-1:0] point_y;
        logic signed [WordW-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [WordW-1:0] image_u;
        logic signed [WordW-1:0] image_v;
        logic [StatusW-1:0] status;
    } t_out;

endpackage

FILE: src/ppp_axis.sv
module ppp_axis import ppp_pkg::*; (
    input  logic                    i_clk,
    input  logic [WordW-1:0]        i_focal,
    input  logic [WordW-1:0]        i_coord,
    input  logic [WordW-1:0]        i_depth,
    input  logic [WordW-1:0]        i_center,
    output logic signed [WordW-1:0] o_value,
    output logic                    o_sat
);

    localparam int Steps = ProdW;
    localparam int RemW = WordW + 1;

    logic [WordW-1:0] r_mag_c;
    logic [WordW-1:0] r_mag_z;
    logic [WordW-1:0] r_focal;
    logic             r_neg0;
    logic [WordW-1:0] r_cen0;
    logic [ProdW-1:0] r_prod;
    logic [WordW-1:0] r_z1;
    logic             r_neg1;
    logic [WordW-1:0] r_cen1;

    logic [ProdW-1:0] r_num [Steps+1];
    logic [RemW-1:0]  r_rem [Steps+1];
    logic [WordW-1:0] r_dz  [Steps+1];
    logic             r_ng  [Steps+1];
    logic [WordW-1:0] r_cn  [Steps+1];

    logic signed [QuoW+1:0] r_sq;
    logic signed [WordW-1:0] r_cen2;

    always_ff @(posedge i_clk) begin
        r_mag_c <= i_coord[WordW-1] ? (~i_coord + 1'b1) : i_coord;
        r_mag_z <= i_depth[WordW-1] ? (~i_depth + 1'b1) : i_depth;
        r_focal <= i_focal;
        r_neg0  <= i_coord[WordW-1] ^ i_depth[WordW-1];
        r_cen0  <= i_center;
        r_prod  <= r_focal * r_mag_c;
        r_z1    <= r_mag_z;
        r_neg1  <= r_neg0;
        r_cen1  <= r_cen0;
    end

    always_comb begin
        r_num[0] = r_prod;
        r_rem[0] = '0;
        r_dz[0]  = r_z1;
        r_ng[0]  = r_neg1;
        r_cn[0]  = r_cen1;
    end

    for (genvar g = 0; g < Steps; g++) begin : g_div
        logic [RemW-1:0] w_trial;
        logic [RemW-1:0] w_diff;
        assign w_trial = {r_rem[g][RemW-2:0], r_num[g][ProdW-1]};
        assign w_diff  = w_trial - {1'b0, r_dz[g]};
        always_ff @(posedge i_clk) begin
            if (!w_diff[RemW-1]) begin
                r_rem[g+1] <= w_diff;
            end else begin
                r_rem[g+1] <= w_trial;
            end
            r_num[g+1] <= {r_num[g][ProdW-2:0], ~w_diff[RemW-1]};
            r_dz[g+1]  <= r_dz[g];
            r_ng[g+1]  <= r_ng[g];
            r_cn[g+1]  <= r_cn[g];
        end
    end

    logic [QuoW-1:0]         w_q;
    logic signed [QuoW+1:0]  w_sum;
    always_comb begin
        if (|r_num[Steps][ProdW-1:QuoW-1]) begin
            w_q = {1'b1, {(QuoW-1){1'b0}}};
        end else begin
            w_q = r_num[Steps][QuoW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq   <= r_ng[Steps] ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
        r_cen2 <= $signed(r_cn[Steps]);
    end

    assign w_sum = r_sq + (QuoW+2)'(r_cen2);

    always_comb begin
        o_sat = 1'b0;
        o_value = w_sum[WordW-1:0];
        if (w_sum > $signed((QuoW+2)'(32'sh7fff_ffff))) begin
            o_value = 32'sh7fff_ffff;
            o_sat = 1'b1;
        end else if (w_sum < -$signed((QuoW+2)'(33'h0_8000_0000))) begin
            o_value = 32'sh8000_0000;
            o_sat = 1'b1;
        end
    end

endmodule

FILE: src/pinhole_point_projection_top.sv
// Throughput: one transaction per cycle; the 64-step restoring divider is fully pipelined.
// Reset: synchronous, active low; clears the valid chain and restores the intrinsics
// to focal length 1.0 and principal point 0. The receiver cannot stall.
module pinhole_point_projection_top import ppp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in                i_data,
    output logic               o_valid,
    output t_out               o_data,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [WordW-1:0]   i_cfg_data
);

    localparam int Lat = ProdW + 3;

    logic [WordW-1:0] r_fx, r_fy, r_cx, r_cy;
    logic [Lat-1:0]   r_vld;
    logic [Lat-1:0]   r_zero;
    logic             r_ovld;
    t_out             r_out;
    logic signed [WordW-1:0] w_u, w_v;
    logic             w_su, w_sv;
    logic             w_go;

    assign busy = 1'b0;
    assign w_go = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= FocalReset;
            r_fy <= FocalReset;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegFocalX:  r_fx <= i_cfg_data;
                RegFocalY:  r_fy <= i_cfg_data;
                RegCenterX: r_cx <= i_cfg_data;
                RegCenterY: r_cy <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    ppp_axis u_axis_u (
        .i_clk(i_clk), .i_focal(r_fx), .i_coord(i_data.point_x),
        .i_depth(i_data.point_z), .i_center(r_cx), .o_value(w_u), .o_sat(w_su)
    );

    ppp_axis u_axis_v (
        .i_clk(i_clk), .i_focal(r_fy), .i_coord(i_data.point_y),
        .i_depth(i_data.point_z), .i_center(r_cy), .o_value(w_v), .o_sat(w_sv)
    );

    always_ff @(posedge i_clk) begin
        r_zero <= {r_zero[Lat-2:0], (i_data.point_z == '0)};
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[Lat-2:0], w_go};
            r_ovld <= r_vld[Lat-1];
        end
        if (r_zero[Lat-1]) begin
            r_out.image_u <= '0;
            r_out.image_v <= '0;
            r_out.status  <= StZero;
        end else begin
            r_out.image_u <= w_u;
            r_out.image_v <= w_v;
            r_out.status  <= (w_su || w_sv) ? StSat : StOk;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

FILE: sim/tb.sv
module tb;
    import ppp_pkg::*;

    localparam int Latency = 67;

    typedef struct {
        logic [WordW-1:0] x, y, z;
        logic             known;
        t_out             res;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in              i_data = '0;
    logic             o_valid;
    t_out             o_data;
    logic             i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [WordW-1:0] i_cfg_data = '0;

    logic [WordW-1:0] fx, fy;
    logic signed [WordW-1:0] cx, cy;
    t_out pending_images[$];
    int   errors = 0;
    int   n_points = 0;
    int   n_zero = 0;
    int   n_sat = 0;

    pinhole_point_projection_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .o_valid(o_valid), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [WordW-1:0] project_coord(input logic [WordW-1:0] focal,
            input logic [WordW-1:0] coord, input logic [WordW-1:0] depth,
            input logic signed [WordW-1:0] centre, inout logic sat);
        logic [63:0] ac, az, prod, q;
        logic signed [63:0] sum;
        ac = coord[31] ? 64'h1_0000_0000 - {32'd0, coord} : {32'd0, coord};
        az = depth[31] ? 64'h1_0000_0000 - {32'd0, depth} : {32'd0, depth};
        prod = {32'd0, focal} * ac;
        q = prod / az;
        if (q > (64'd1 << 34)) q = 64'd1 << 34;
        sum = (coord[31] != depth[31]) ? -$signed(q) : $signed(q);
        sum = sum + centre;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            sat = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            sat = 1'b1;
        end
        return sum[31:0];
    endfunction

    function automatic t_out project_point(input t_in p);
        t_out r;
        logic sat;
        sat = 1'b0;
        r = '0;
        if (p.point_z == 0) begin
            r.status = StZero;
            return r;
        end
        r.image_u = project_coord(fx, p.point_x, p.point_z, cx, sat);
        r.image_v = project_coord(fy, p.point_y, p.point_z, cy, sat);
        r.status = sat ? StSat : StOk;
        return r;
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegFocalX: fx = val;
            RegFocalY: fy = val;
            RegCenterX: cx = val;
            default: cy = val;
        endcase
    endtask

    task automatic drain;
        while (pending_images.size() != 0) @(posedge i_clk);
        repeat (Latency + 5) @(posedge i_clk);
    endtask

    task automatic send_point(input t_in p, input logic known, input t_out res);
        t_out e;
        start <= 1'b1;
        i_data <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e = project_point(p);
        if (known && e !== res) begin
            $error("table row: expected %h, model gives %h", res, e);
            errors++;
        end
        pending_images.insert(pending_images.size(), e);
        n_points++;
        if (e.status == StZero) n_zero++;
        if (e.status == StSat) n_sat++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_out e;
            if (pending_images.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
            end else begin
                e = pending_images.pop_front();
                if (o_data.image_u !== e.image_u) begin
                    $error("image_u expected %h actual %h", e.image_u, o_data.image_u);
                    errors++;
                end
                if (o_data.image_v !== e.image_v) begin
                    $error("image_v expected %h actual %h", e.image_v, o_data.image_v);
                    errors++;
                end
                if (o_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_data.status);
                    errors++;
                end
            end
        end
    end

    function automatic logic [WordW-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            3: return $urandom_range(0, 3) - 2;
            4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row rows[10];
        t_in  p;
        fx = FocalReset;
        fy = FocalReset;
        cx = 0;
        cy = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows[0] = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1,
                    '{32'h0001_0000, 32'h0002_0000, StOk}};
        rows[1] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1, '{0, 0, StZero}};
        rows[2] = '{32'h0, 32'h0, 32'h0, 1'b1, '{0, 0, StZero}};
        rows[3] = '{32'h7fff_ffff, 32'h0, 32'h1, 1'b1,
                    '{32'h7fff_ffff, 32'h0, StSat}};
        rows[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h1, 1'b1,
                    '{32'h8000_0000, 32'h7fff_ffff, StSat}};
        rows[5] = '{32'h0003_0000, 32'hfffd_0000, 32'hffff_0000, 1'b1,
                    '{32'hfffd_0000, 32'h0003_0000, StOk}};
        rows[6] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '{0, 0, 0}};
        rows[7] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '{0, 0, 0}};
        rows[8] = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0003, 1'b0, '{0, 0, 0}};
        rows[9] = '{32'h0000_8000, 32'hffff_8000, 32'h0002_0000, 1'b0, '{0, 0, 0}};
        foreach (rows[i]) begin
            p = '{rows[i].x, rows[i].y, rows[i].z};
            send_point(p, rows[i].known, rows[i].res);
        end
        idle_cycles(0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(RegFocalX, 32'h0);
                    write_reg(RegFocalY, 32'hffff_ffff);
                    write_reg(RegCenterX, 32'h7fff_ffff);
                    write_reg(RegCenterY, 32'h8000_0000);
                end
                1: begin
                    write_reg(RegFocalX, 32'hffff_ffff);
                    write_reg(RegFocalY, 32'h0);
                    write_reg(RegCenterX, 32'h8000_0000);
                    write_reg(RegCenterY, 32'h7fff_ffff);
                end
                5: begin
                    write_reg(RegFocalX, FocalReset);
                    write_reg(RegFocalY, FocalReset);
                    write_reg(RegCenterX, 32'h0);
                    write_reg(RegCenterY, 32'h0);
                end
                default: begin
                    write_reg(RegFocalX, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0400_0000));
                    write_reg(RegFocalY, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0400_0000));
                    write_reg(RegCenterX, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
                    write_reg(RegCenterY, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
                end
            endcase
            for (int n = 0; n < 215; ) begin
                int burst;
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && n < 215; k++, n++) begin
                    p.point_x = rand_word();
                    p.point_y = rand_word();
                    p.point_z = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_word();
                    send_point(p, 1'b0, '0);
                end
                if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 8));
                if (n == 100 && phase == 2) begin
                    idle_cycles(0);
                    while (pending_images.size() != 0) @(posedge i_clk);
                end
            end
            idle_cycles(0);
            drain();
        end

        $display("Projected %0d points over seven register settings.", n_points);
        $display("Zero-depth results: %0d, saturated results: %0d.", n_zero, n_sat);
        if (errors == 0 && pending_images.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
src/ppp_pkg.sv
src/ppp_axis.sv
src/pinhole_point_projection_top.sv
sim/tb.sv
